// File: hw/rtl/frame_delta_3bit_encoder_top_assert.svh
// Assertion macros used by the frame delta encoder top level.
`ifndef FRAME_DELTA_3BIT_ENCODER_TOP_ASSERT_SVH
`define FRAME_DELTA_3BIT_ENCODER_TOP_ASSERT_SVH

// When cond holds at an edge, prop must hold at the same edge.
`define FD3E_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("frame delta encoder check failed");

// When cond holds at an edge, prop must hold at the next edge.
`define FD3E_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("frame delta encoder check failed");

`endif

// File: hw/rtl/fd3e_pkg.sv
// Shared types and constants of the frame delta encoder.
package fd3e_pkg;

   localparam int PIXEL_W   = 8;
   localparam int CODE_W    = 3;
   localparam int WORD_W    = 63;
   localparam int MAX_CODES = 21;
   localparam int CFG_W     = 21;

   localparam logic [CFG_W-1:0]  CFG_RESET = 21'd1048576;
   localparam logic [CODE_W-1:0] ESC_CODE  = 3'b100;

   // Pixel held in the difference stage.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_end;
   } fd3e_stage_type;

   // Everything one pixel leaves for the output side.
   typedef struct packed {
      logic                      has_escape;
      logic signed [PIXEL_W-1:0] escape_value;
      logic                      has_word;
      logic [WORD_W-1:0]         code_word;
      logic                      frame_end;
   } fd3e_entry_type;

   // One result item as seen on the output channel.
   typedef struct packed {
      logic                      is_escape;
      logic [WORD_W-1:0]         code_word;
      logic signed [PIXEL_W-1:0] escape_value;
      logic                      frame_end;
      logic                      last_of_item;
   } fd3e_result_type;

endpackage

// File: hw/rtl/frame_delta_3bit_encoder_top.sv
// Top level of the frame delta encoder with 3-bit codes.
//
// The block takes one 8-bit pixel item per clock in raster order, unless
// stalled, subtracts the pixel at the same position of the previous frame
// modulo 256, and codes differences from -3 to 3 as 3-bit two's complement;
// anything else becomes the escape code 100 and also produces an escape
// byte result. Codes are packed CODES_PER_WORD to a word, code k at bits
// 3k..3k+2, and a word goes out when full or at the last pixel of the
// frame. A pixel yields zero, one or two result items; the escape byte
// comes before the word, and last_of_item marks the final one. The input
// stalls while the two-entry result queue is full and blocks the coding
// stage; the output carries one result item per clock while rsp_stall is
// low. The accepting edge registers the pixel and reads the previous-frame
// memory; a later edge, once the queue has room, writes the coded entry
// into the queue, which offers it. The previous frame reads as zero after
// reset through a fill count, so there is no clearing pass. A write to
// frame_pixels takes effect at once; zero counts as one and values above
// MAX_PIXELS saturate.
module frame_delta_3bit_encoder_top
   import fd3e_pkg::*;
#(
   parameter int MAX_PIXELS     = 1048576,
   parameter int CODES_PER_WORD = 21
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CFG_W-1:0]          csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_W-1:0]        req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_is_escape,
   output logic [WORD_W-1:0]         rsp_code_word,
   output logic signed [PIXEL_W-1:0] rsp_escape_value,
   output logic                      rsp_frame_end,
   output logic                      rsp_last_of_item
);

   `include "frame_delta_3bit_encoder_top_assert.svh"

   localparam int POS_W  = $clog2(MAX_PIXELS);
   localparam int FILL_W = $clog2(MAX_PIXELS + 1);
   localparam int CMP_W  = (FILL_W > CFG_W ? FILL_W : CFG_W) + 1;

   logic [CFG_W-1:0]   frame_pixels_ff;
   logic [CFG_W-1:0]   frame_pixels_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   fd3e_stage_type     s1_ff;
   fd3e_stage_type     s1_in;
   logic [CMP_W-1:0]   size_raw;
   logic [CMP_W-1:0]   size_eff;
   logic [CMP_W-1:0]   pos_next;
   logic               req_last;
   logic               accept;
   logic               advance;
   logic               queue_ready;
   logic               push;
   fd3e_entry_type     entry;
   fd3e_result_type    result;
   logic [PIXEL_W-1:0] prev_pixel;
   logic               prev_known;

   // Frame size as used: zero means one pixel, oversize clamps to the store.
   assign size_raw = CMP_W'(frame_pixels_ff);
   always_comb begin
      size_eff = size_raw;
      if (size_raw == '0) begin
         size_eff = CMP_W'(1);
      end else if (size_raw > CMP_W'(MAX_PIXELS)) begin
         size_eff = CMP_W'(MAX_PIXELS);
      end
   end

   // A pixel ends the frame once its position reaches the last one, which
   // also covers a frame size lowered below the current position.
   assign pos_next = CMP_W'(pos_ff) + CMP_W'(1);
   assign req_last = pos_next >= size_eff;

   // The coding stage moves on whenever the queue has room for its entry.
   assign advance   = s1_valid_ff && queue_ready;
   assign req_stall = s1_valid_ff && !queue_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      frame_pixels_in = csr_wr_en ? csr_wr_data : frame_pixels_ff;
      pos_in          = pos_ff;
      if (accept) begin
         pos_in = req_last ? '0 : pos_next[POS_W-1:0];
      end
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in     = 1'b1;
         s1_in.pixel     = req_pixel;
         s1_in.frame_end = req_last;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= CFG_RESET;
         pos_ff          <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         frame_pixels_ff <= frame_pixels_in;
         pos_ff          <= pos_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // The store is written with the new pixel in the same cycle it is read,
   // so the read returns the previous frame's value at that position.
   fd3e_frame_store #(
      .DEPTH (MAX_PIXELS)
   ) u_frame_store (
      .clock    (clock),
      .reset    (reset),
      .access   (accept),
      .addr     (pos_ff),
      .wr_data  (req_pixel),
      .rd_data  (prev_pixel),
      .rd_known (prev_known)
   );

   fd3e_packer #(
      .CODES_PER_WORD (CODES_PER_WORD)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .stage      (s1_ff),
      .prev_pixel (prev_pixel),
      .prev_known (prev_known),
      .push       (push),
      .entry      (entry)
   );

   fd3e_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry     (entry),
      .ready     (queue_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .result    (result)
   );

   assign rsp_is_escape    = result.is_escape;
   assign rsp_code_word    = result.code_word;
   assign rsp_escape_value = result.escape_value;
   assign rsp_frame_end    = result.frame_end;
   assign rsp_last_of_item = result.last_of_item;

   // The last pixel of a frame sends the position back to zero.
   `FD3E_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && req_last, pos_ff == '0)
   // The position never leaves the frame store.
   `FD3E_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, CMP_W'(pos_ff) < CMP_W'(MAX_PIXELS))
   // A blocked coding stage keeps its pixel.
   `FD3E_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !queue_ready, s1_valid_ff)
   // An entry pushed into the queue shows up as a result item.
   `FD3E_ASSERT_NEXT(a_push_visible, clock, reset, push, rsp_valid)

endmodule

// File: hw/rtl/fd3e_frame_store.sv
// Previous-frame pixel memory with a fill count standing in for the reset clear.
module fd3e_frame_store
   import fd3e_pkg::*;
#(
   parameter int DEPTH = 1048576
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     access,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [PIXEL_W-1:0]       wr_data,
   output logic [PIXEL_W-1:0]       rd_data,
   output logic                     rd_known
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [PIXEL_W-1:0] frame_mem_ff [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               rd_known_ff;
   logic               rd_known_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [FILL_W-1:0]  addr_ext;

   // Positions always run upward from zero, so every address below the fill
   // count has been written and everything else still reads as zero.
   assign addr_ext    = FILL_W'(addr);
   assign rd_known_in = addr_ext < fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (access && (addr_ext == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         rd_known_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (access) begin
            rd_known_ff <= rd_known_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (access) begin
         frame_mem_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (access) begin
         rd_data_ff <= frame_mem_ff[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_known = rd_known_ff;

endmodule

// File: hw/rtl/fd3e_packer.sv
// Difference, 3-bit coding and word packing for one pixel per cycle on advance.
module fd3e_packer
   import fd3e_pkg::*;
#(
   parameter int CODES_PER_WORD = 21
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  fd3e_stage_type     stage,
   input  logic [PIXEL_W-1:0] prev_pixel,
   input  logic               prev_known,
   output logic               push,
   output fd3e_entry_type     entry
);

   localparam int CNT_W = $clog2(CODES_PER_WORD + 1);

   logic [WORD_W-1:0]  acc_ff;
   logic [WORD_W-1:0]  acc_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [PIXEL_W-1:0] prev;
   logic [PIXEL_W-1:0] diff;
   logic               escape;
   logic [CODE_W-1:0]  code;
   logic [WORD_W-1:0]  word_new;
   logic               word_full;
   logic               emit_word;

   assign prev   = prev_known ? prev_pixel : '0;
   assign diff   = stage.pixel - prev;
   assign escape = !((diff <= 8'd3) || (diff >= 8'd253));
   assign code   = escape ? ESC_CODE : diff[CODE_W-1:0];

   // Drop the new code into its slot; slots beyond the word size stay zero.
   always_comb begin
      word_new = acc_ff;
      for (int k = 0; k < MAX_CODES; k++) begin
         if ((k < CODES_PER_WORD) && (cnt_ff == CNT_W'(k))) begin
            word_new[CODE_W*k +: CODE_W] = code;
         end
      end
   end

   assign word_full = cnt_ff == CNT_W'(CODES_PER_WORD - 1);
   assign emit_word = word_full || stage.frame_end;

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (advance) begin
         if (emit_word) begin
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = word_new;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign push               = advance && (escape || emit_word);
   assign entry.has_escape   = escape;
   assign entry.escape_value = diff;
   assign entry.has_word     = emit_word;
   assign entry.code_word    = word_new;
   assign entry.frame_end    = stage.frame_end;

endmodule

// File: hw/rtl/fd3e_result_queue.sv
// Two-entry queue that turns each pixel's entry into one or two result items.
module fd3e_result_queue
   import fd3e_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  fd3e_entry_type  entry,
   output logic            ready,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fd3e_result_type result
);

   fd3e_entry_type entry_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;
   logic           phase_ff;
   logic           phase_in;
   fd3e_entry_type head;
   logic           send_escape;
   logic           take;
   logic           entry_done;

   assign head        = entry_ff[rd_ptr_ff];
   assign rsp_valid   = count_ff != 2'd0;
   // The escape byte of an entry goes out before its word.
   assign send_escape = head.has_escape && !phase_ff;
   assign take        = rsp_valid && !rsp_stall;
   assign entry_done  = take && (phase_ff || !head.has_escape || !head.has_word);
   assign ready       = (count_ff != 2'd2) || entry_done;

   always_comb begin
      result.is_escape    = send_escape;
      result.code_word    = send_escape ? '0 : head.code_word;
      result.escape_value = send_escape ? head.escape_value : '0;
      result.frame_end    = head.frame_end;
      result.last_of_item = send_escape ? !head.has_word : 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (take) begin
         phase_in = !entry_done;
      end
      if (entry_done) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + 2'(push) - 2'(entry_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: bench/tb_frame_delta_3bit_encoder_top.sv
// Self-checking testbench for the frame delta 3-bit encoder top level.
module tb_frame_delta_3bit_encoder_top
   import fd3e_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PIXELS     = 1048576;
   localparam int CODES_PER_WORD = 21;
   // Timeout bound, far beyond what a correct run needs.
   localparam int CYCLE_LIMIT    = 200000;
   // Receiver hold-off that is long enough to back the block up to its input.
   localparam int HOLD_CYCLES    = 150;
   localparam int HOLD_AT_PIXEL  = 400;
   // Pixels still waiting to be sent when the hold-off starts.
   localparam int HOLD_BACKLOG   = 40;
   // Accepted-pixel window in which neither side inserts idle cycles.
   localparam int QUIET_FROM     = 600;
   localparam int QUIET_TO       = 800;

   logic                      clock;
   logic                      reset        = 1'b1;
   logic                      csr_wr_en    = 1'b0;
   logic [CFG_W-1:0]          csr_wr_data  = '0;
   logic                      req_valid    = 1'b0;
   logic                      req_stall;
   logic [PIXEL_W-1:0]        req_pixel    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall    = 1'b0;
   logic                      rsp_is_escape;
   logic [WORD_W-1:0]         rsp_code_word;
   logic signed [PIXEL_W-1:0] rsp_escape_value;
   logic                      rsp_frame_end;
   logic                      rsp_last_of_item;

   frame_delta_3bit_encoder_top #(
      .MAX_PIXELS     (MAX_PIXELS),
      .CODES_PER_WORD (CODES_PER_WORD)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_escape    (rsp_is_escape),
      .rsp_code_word    (rsp_code_word),
      .rsp_escape_value (rsp_escape_value),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // Pixels waiting to be offered on the input channel, in raster order.
   logic [PIXEL_W-1:0] pixels_to_send [$];
   // Code words and escape bytes that the accepted pixels must produce, oldest first.
   fd3e_result_type    coded_stream [$];

   int unsigned cycle_count     = 0;
   int unsigned accepted_pixels = 0;
   int unsigned error_count     = 0;
   int unsigned hold_left       = 0;
   bit          hold_done       = 1'b0;
   bit          quiet;

   // Encoder state as the block should hold it. The previous frame starts at zero.
   bit [PIXEL_W-1:0]  prior_frame [MAX_PIXELS];
   int unsigned       frame_pos;
   logic [WORD_W-1:0] word_acc;
   int unsigned       codes_in_word;
   logic [CFG_W-1:0]  frame_pixels_reg;

   // Shadow of the frame that the stimulus has queued so far. It lets the
   // generator pick pixels close to the previous frame, so that the short
   // codes are reached as often as the escapes.
   bit [PIXEL_W-1:0]  queued_frame [MAX_PIXELS];
   int unsigned       queued_pos;
   int unsigned       queued_len;

   // Frame length as the block applies it: zero counts as one, and anything
   // above the store size saturates.
   function automatic int unsigned frame_len(logic [CFG_W-1:0] value);
      if (value == '0) return 1;
      if (value > MAX_PIXELS) return MAX_PIXELS;
      return 32'(value);
   endfunction

   // Codes one accepted pixel and appends the results it must cause.
   function automatic void encode_pixel(logic [PIXEL_W-1:0] pix);
      int unsigned        pos;
      logic [PIXEL_W-1:0] diff;
      logic [CODE_W-1:0]  code;
      bit                 escape;
      bit                 ends_frame;
      bit                 word_out;
      fd3e_result_type    res;

      pos = frame_pos;
      if (pos >= MAX_PIXELS) pos = 0;
      diff = pix - prior_frame[pos];
      prior_frame[pos] = pix;

      // Differences from -3 to 3 read as 0..3 or 0xFD..0xFF as a byte.
      escape = !(diff <= 8'd3 || diff >= 8'hFD);
      code = escape ? ESC_CODE : diff[CODE_W-1:0];
      if (codes_in_word < CODES_PER_WORD) begin
         word_acc = word_acc | (WORD_W'(code) << (CODE_W * codes_in_word));
         codes_in_word++;
      end

      ends_frame = (pos + 1 >= frame_len(frame_pixels_reg));
      word_out = (codes_in_word >= CODES_PER_WORD) || ends_frame;

      // The escape byte goes ahead of any word that this pixel closes.
      if (escape) begin
         res.is_escape    = 1'b1;
         res.code_word    = '0;
         res.escape_value = diff;
         res.frame_end    = ends_frame;
         res.last_of_item = !word_out;
         coded_stream.push_back(res);
      end
      if (word_out) begin
         res.is_escape    = 1'b0;
         res.code_word    = word_acc;
         res.escape_value = '0;
         res.frame_end    = ends_frame;
         res.last_of_item = 1'b1;
         coded_stream.push_back(res);
         word_acc = '0;
         codes_in_word = 0;
      end

      frame_pos = ends_frame ? 0 : pos + 1;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic queue_pixel(logic [PIXEL_W-1:0] pix);
      pixels_to_send.push_back(pix);
      queued_frame[queued_pos] = pix;
      queued_pos = (queued_pos + 1 >= queued_len) ? 0 : queued_pos + 1;
   endtask

   // Queues the pixel that differs by delta, modulo 256, from the previous frame.
   task automatic queue_delta(int delta);
      queue_pixel(PIXEL_W'(int'(queued_frame[queued_pos]) + delta));
   endtask

   task automatic queue_random_pixel();
      int pick;
      int wide_steps [6] = '{4, -4, 127, -128, 5, -5};
      int extremes [3] = '{0, 255, 128};

      pick = $urandom_range(99);
      if (pick < 55) begin
         queue_delta(int'($urandom_range(6)) - 3);
      end else if (pick < 65) begin
         queue_delta(wide_steps[$urandom_range(5)]);
      end else if (pick < 75) begin
         queue_pixel(PIXEL_W'(extremes[$urandom_range(2)]));
      end else begin
         queue_pixel(PIXEL_W'($urandom_range(255)));
      end
   endtask

   // Waits until the block has drained, then writes the frame length. The
   // drain is checked at the falling edge, when the driver and the monitor
   // have settled. The extra cycles cover pixels that produce no result but
   // are still in the pipeline when the last result has come out.
   task automatic set_frame_pixels(logic [CFG_W-1:0] value);
      while (pixels_to_send.size() != 0 || req_valid || coded_stream.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_pixels_reg = value;
      queued_len = frame_len(value);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   assign quiet = (accepted_pixels >= QUIET_FROM) && (accepted_pixels < QUIET_TO);

   // Input side. An offered pixel stays put until the block takes it; a new
   // one, or an idle cycle, is chosen only after that.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_pixel(req_pixel);
            accepted_pixels <= accepted_pixels + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pixels_to_send.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
               req_valid <= 1'b1;
               req_pixel <= pixels_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output side. Every result taken is checked against the oldest
   // prediction, field by field. Once in the run the receiver holds off for
   // a long stretch while plenty of pixels are still waiting, so that the
   // block has to stall its input.
   always @(posedge clock) begin : result_monitor
      fd3e_result_type want;

      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coded_stream.size() == 0) begin
               report_mismatch("result arrived with nothing predicted");
            end else begin
               want = coded_stream.pop_front();
               if (rsp_is_escape !== want.is_escape)
                  report_mismatch($sformatf("is_escape %b, predicted %b",
                                            rsp_is_escape, want.is_escape));
               if (rsp_code_word !== want.code_word)
                  report_mismatch($sformatf("code_word %h, predicted %h",
                                            rsp_code_word, want.code_word));
               if (rsp_escape_value !== want.escape_value)
                  report_mismatch($sformatf("escape_value %h, predicted %h",
                                            rsp_escape_value, want.escape_value));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, predicted %b",
                                            rsp_frame_end, want.frame_end));
               if (rsp_last_of_item !== want.last_of_item)
                  report_mismatch($sformatf("last_of_item %b, predicted %b",
                                            rsp_last_of_item, want.last_of_item));
            end
         end

         if (!hold_done && accepted_pixels >= HOLD_AT_PIXEL &&
             pixels_to_send.size() >= HOLD_BACKLOG) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 20);
         end
      end
   end

   // Stimulus: a short directed part, then random phases under a range of
   // frame lengths. Between phases the sender waits for the block to drain.
   initial begin
      int          phase_sizes [12] = '{21'h1FFFFF, 1, 2, 20, 21, 22, 43, 64, 130, 0, 1048576, 7};
      int unsigned size;
      int unsigned count;

      frame_pos = 0;
      word_acc = '0;
      codes_in_word = 0;
      frame_pixels_reg = CFG_RESET;
      queued_pos = 0;
      queued_len = frame_len(CFG_RESET);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Under the reset frame length, coded against the cleared store: zero,
      // minus one, the -128 and +127 escapes, the +4 and -4 escapes, and the
      // largest short codes +3 and -3.
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      queue_pixel(8'd128);
      queue_pixel(8'd127);
      queue_pixel(8'd4);
      queue_pixel(8'd252);
      queue_pixel(8'd3);
      queue_pixel(8'd253);

      // Zero means a one-pixel frame. The position is already past the new
      // end, so the next pixel closes the frame. After that every pixel is a
      // frame of its own, with its word emitted partly filled.
      set_frame_pixels('0);
      queue_delta(2);
      queue_delta(0);
      queue_delta(1);
      queue_delta(2);
      queue_delta(3);
      queue_delta(-1);
      queue_delta(-2);
      queue_delta(-3);
      queue_delta(4);
      queue_delta(-4);
      queue_delta(127);
      queue_delta(-128);

      // Random phases. The first writes the largest register value, which
      // saturates to the store size; one length is drawn at random.
      for (int i = 0; i < 12; i++) begin
         size = (phase_sizes[i] == 0) ? $urandom_range(1, 500) : phase_sizes[i];
         set_frame_pixels(CFG_W'(size));
         count = $urandom_range(60, 110);
         for (int j = 0; j < count; j++) begin
            queue_random_pixel();
         end
      end

      while (pixels_to_send.size() != 0 || req_valid || coded_stream.size() != 0) begin
         @(negedge clock);
      end
      // Any stray result would show up within the pipeline latency.
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/fd3e_pkg.sv
hw/rtl/fd3e_frame_store.sv
hw/rtl/fd3e_packer.sv
hw/rtl/fd3e_result_queue.sv
hw/rtl/frame_delta_3bit_encoder_top.sv
bench/tb_frame_delta_3bit_encoder_top.sv
